// File: hdl/mscdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscdt_pkg
// Shared codes and control/status types of the countdown timer table.
// ----------------------------------------------------------------------------
package mscdt_pkg;

    localparam int KIND_W = 2;
    localparam int TIME_W = 32;
    localparam int ID_W   = 16;
    localparam int RES_W  = 3;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // result codes
    localparam logic [RES_W-1:0] RES_ADDED    = 3'd0;
    localparam logic [RES_W-1:0] RES_FULL     = 3'd1;
    localparam logic [RES_W-1:0] RES_REMOVED  = 3'd2;
    localparam logic [RES_W-1:0] RES_NOTFOUND = 3'd3;
    localparam logic [RES_W-1:0] RES_EXPIRED  = 3'd4;
    localparam logic [RES_W-1:0] RES_TICKDONE = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the item and rewind the slot walk
        logic scan;   // walk slots, evaluate one per cycle
        logic fin;    // emit the tick-done beat
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;  // the walk has finished with this evaluation
        logic is_tick;   // the item in progress is a tick
    } sts_t;

endpackage

// File: hdl/multi_slot_countdown_timer_unit.sv
`timescale 1ns / 1ps
// Add/remove: one result strobe, registered after the evaluation of the slot where the walk stops.
// Tick: expiry beats in slot order, then a tick-done beat once the walk has covered every slot.
// Items are taken one at a time: busy holds off the next until the walk, one slot per cycle
// over the RAM read port, is through. Results are strobed once and cannot be stalled.
// Reset: all slots free and the id counter at zero; no clearing pass.
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_unit
// Table of countdown timers with add, remove and tick commands.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_unit #(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mscdt_pkg::KIND_W-1:0] kind,
    input  logic [mscdt_pkg::TIME_W-1:0] duration,
    input  logic [mscdt_pkg::ID_W-1:0]   timer_id,
    input  logic [mscdt_pkg::TIME_W-1:0] delta,
    output logic                         result_valid,
    output logic [mscdt_pkg::RES_W-1:0]  event_res,
    output logic [mscdt_pkg::ID_W-1:0]   event_id,
    output logic                         last
);
    import mscdt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mscdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    mscdt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (kind),
        .duration     (duration),
        .timer_id     (timer_id),
        .delta        (delta),
        .sts          (sts),
        .result_valid (result_valid),
        .event_res    (event_res),
        .event_id     (event_id),
        .last         (last)
    );

endmodule

// File: hdl/mscdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mscdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/mscdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscdt_ctrl
// Sequencer: accepts an item, runs the slot walk, closes a tick with done.
// ----------------------------------------------------------------------------
module mscdt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mscdt_pkg::KIND_W-1:0] kind,
    input  mscdt_pkg::sts_t              sts,
    output mscdt_pkg::cmd_t              cmd,
    output logic                         busy
);
    import mscdt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.fin    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // an unused kind is ignored and the sequencer stays idle
                if (start && (kind != KIND_NONE))
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = sts.is_tick ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_tick_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && sts.scan_end && sts.is_tick) |=> state_reg == ST_DONE)
        else $error("tick walk did not close with tick done");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start && kind != KIND_NONE) |=> busy)
        else $error("accepted item did not raise busy");

endmodule

// File: hdl/mscdt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mscdt_dp
// Slot table datapath: live bits, id and remaining-time RAMs, a one-slot
// per cycle walk with a read stage and an evaluate stage, result registers.
// ----------------------------------------------------------------------------
module mscdt_dp #(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mscdt_pkg::cmd_t              cmd,
    input  logic [mscdt_pkg::KIND_W-1:0] kind,
    input  logic [mscdt_pkg::TIME_W-1:0] duration,
    input  logic [mscdt_pkg::ID_W-1:0]   timer_id,
    input  logic [mscdt_pkg::TIME_W-1:0] delta,
    output mscdt_pkg::sts_t              sts,
    output logic                         result_valid,
    output logic [mscdt_pkg::RES_W-1:0]  event_res,
    output logic [mscdt_pkg::ID_W-1:0]   event_id,
    output logic                         last
);
    import mscdt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [KIND_W-1:0] kind_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [ID_W-1:0]   rid_reg;
    logic [TIME_W-1:0] delta_reg;

    logic [CW-1:0]     idx_reg,      idx_next;
    logic              eval_vld_reg, eval_vld_next;
    logic [IW-1:0]     eval_idx_reg;
    logic [SLOTS-1:0]  live_reg,     live_next;
    logic [ID_W-1:0]   next_id_reg,  next_id_next;

    logic              res_vld_reg,  res_vld_next;
    logic [RES_W-1:0]  res_code_reg, res_code_next;
    logic [ID_W-1:0]   res_id_reg,   res_id_next;
    logic              res_last_reg, res_last_next;

    logic              issue;
    logic              eval;
    logic              e_live;
    logic              e_last;
    logic              hit;
    logic              id_we;
    logic              rem_we;
    logic [TIME_W-1:0] rem_wdata;
    logic [ID_W-1:0]   id_rd;
    logic [TIME_W-1:0] rem_rd;

    assign issue  = cmd.scan && (idx_reg < CW'(SLOTS));
    assign eval   = eval_vld_reg && cmd.scan;
    assign e_live = live_reg[eval_idx_reg];
    assign e_last = (eval_idx_reg == IW'(SLOTS - 1));

    mscdt_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (eval_idx_reg),
        .wdata (next_id_reg),
        .raddr (idx_reg[IW-1:0]),
        .rdata (id_rd)
    );

    mscdt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOTS)
    ) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (eval_idx_reg),
        .wdata (rem_wdata),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rem_rd)
    );

    always_comb
    begin
        idx_next      = idx_reg;
        eval_vld_next = issue;
        live_next     = live_reg;
        next_id_next  = next_id_reg;
        res_vld_next  = 1'b0;
        res_code_next = res_code_reg;
        res_id_next   = res_id_reg;
        res_last_next = res_last_reg;
        id_we         = 1'b0;
        rem_we        = 1'b0;
        rem_wdata     = dur_reg;
        hit           = 1'b0;

        if (cmd.load)
        begin
            idx_next      = '0;
            eval_vld_next = 1'b0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + CW'(1);
        end

        case (kind_reg)
            KIND_ADD:
            begin
                if (eval)
                begin
                    if (!e_live)
                    begin
                        live_next[eval_idx_reg] = 1'b1;
                        id_we         = 1'b1;
                        rem_we        = 1'b1;
                        res_vld_next  = 1'b1;
                        res_code_next = RES_ADDED;
                        res_id_next   = next_id_reg;
                        res_last_next = 1'b1;
                        next_id_next  = next_id_reg + ID_W'(1);
                        hit           = 1'b1;
                    end
                    else if (e_last)
                    begin
                        res_vld_next  = 1'b1;
                        res_code_next = RES_FULL;
                        res_id_next   = '0;
                        res_last_next = 1'b1;
                    end
                end
            end
            KIND_REMOVE:
            begin
                if (eval)
                begin
                    if (e_live && (id_rd == rid_reg))
                    begin
                        live_next[eval_idx_reg] = 1'b0;
                        res_vld_next  = 1'b1;
                        res_code_next = RES_REMOVED;
                        res_id_next   = rid_reg;
                        res_last_next = 1'b1;
                        hit           = 1'b1;
                    end
                    else if (e_last)
                    begin
                        res_vld_next  = 1'b1;
                        res_code_next = RES_NOTFOUND;
                        res_id_next   = rid_reg;
                        res_last_next = 1'b1;
                    end
                end
            end
            KIND_TICK:
            begin
                if (eval && e_live)
                begin
                    if (delta_reg >= rem_rd)
                    begin
                        live_next[eval_idx_reg] = 1'b0;
                        res_vld_next  = 1'b1;
                        res_code_next = RES_EXPIRED;
                        res_id_next   = id_rd;
                        res_last_next = 1'b0;
                    end
                    else
                    begin
                        // survivor keeps what is left, no underflow here
                        rem_we    = 1'b1;
                        rem_wdata = rem_rd - delta_reg;
                    end
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase

        if (cmd.fin)
        begin
            res_vld_next  = 1'b1;
            res_code_next = RES_TICKDONE;
            res_id_next   = '0;
            res_last_next = 1'b1;
        end
    end

    assign sts.scan_end = eval && (hit || e_last);
    assign sts.is_tick  = (kind_reg == KIND_TICK);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dur_reg   <= duration;
            rid_reg   <= timer_id;
            delta_reg <= delta;
        end
        eval_idx_reg <= idx_reg[IW-1:0];
        res_code_reg <= res_code_next;
        res_id_reg   <= res_id_next;
        res_last_reg <= res_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_NONE;
            idx_reg      <= '0;
            eval_vld_reg <= 1'b0;
            live_reg     <= '0;
            next_id_reg  <= '0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg <= kind;
            end
            idx_reg      <= idx_next;
            eval_vld_reg <= eval_vld_next;
            live_reg     <= live_next;
            next_id_reg  <= next_id_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign event_res    = res_code_reg;
    assign event_id     = res_id_reg;
    assign last         = res_last_reg;

    a_mid_beat_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && !res_last_reg) |-> (res_code_reg == RES_EXPIRED))
        else $error("non-final beat is not an expiry");

    a_one_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(live_reg) <= $countones($past(live_reg)) + 1)
        else $error("more than one slot allocated in a cycle");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CW'(SLOTS))
        else $error("slot walk ran past the table");

endmodule
